FILE: hdl/uer_pkg.sv
// ----------------------------------------------------------------------------
// uer_pkg
// Types and constants shared by the echo ranging controller, its datapath,
// its channel interfaces and its checker.
// ----------------------------------------------------------------------------
package uer_pkg;

	// Register indexes on the configuration channel.
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_TICKS_PER_MS  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TRIGGER_TICKS = 1'd1;

	localparam logic [15:0] TICKS_PER_MS_RST  = 16'd1000;
	localparam logic [15:0] TRIGGER_TICKS_RST = 16'd10;

	localparam int SENSOR_COUNT = 8;

	// Conversion constants.
	localparam logic [9:0]  US_PER_MS   = 10'd1000;
	localparam logic [6:0]  CM_SCALE    = 7'd100;
	localparam int          AIR_W       = 13;
	localparam logic [12:0] AIR_BASE    = 13'd3313;
	localparam logic [12:0] AIR_SLOPE   = 13'd6;
	// floor(a / 100) == (a * 5243) >> 19 for every a below 43699.
	localparam logic [12:0] RECIP_100   = 13'd5243;
	localparam int          RECIP_SHIFT = 19;

	typedef struct packed {
		logic       cmd;
		logic       echo_level;
		logic [2:0] sensor_index;
		logic [7:0] temperature_c;
	} tick_item_t;

	typedef struct packed {
		logic [7:0]  trigger_lines;
		logic        busy_res;
		logic        done_res;
		logic        no_echo;
		logic [15:0] microseconds;
		logic [10:0] centimeters;
	} result_item_t;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_TRIG,
		PH_WAIT,
		PH_MEAS
	} phase_t;

	typedef enum logic [1:0] {
		SQ_READY,
		SQ_DIV1,
		SQ_MUL2,
		SQ_DIV2
	} seq_t;

	typedef struct packed {
		logic tick;
		logic cnt_clear;
		logic latch;
		logic pulse_inc;
		logic trig_on;
		logic busy;
		logic done;
		logic noecho;
		logic push;
		logic from_div;
		logic mul1;
		logic mul2;
		logic div_step;
	} uer_cmd_t;

	typedef struct packed {
		logic start_req;
		logic rise;
		logic fall;
		logic wrapped;
		logic trig_done;
		logic div_busy;
		logic out_full;
	} uer_stat_t;

endpackage

FILE: hdl/uer_tick_if.sv
// ----------------------------------------------------------------------------
// uer_tick_if
// Channel that carries one timer tick with its echo level, start request, sensor index and temperature.
// ----------------------------------------------------------------------------
interface uer_tick_if;
	import uer_pkg::*;

	logic       valid;
	logic       ready;
	tick_item_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

FILE: hdl/uer_result_if.sv
// ----------------------------------------------------------------------------
// uer_result_if
// Channel that carries one result item per tick.
// ----------------------------------------------------------------------------
interface uer_result_if;
	import uer_pkg::*;

	logic         valid;
	logic         ready;
	result_item_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

FILE: hdl/uer_cfg_if.sv
// ----------------------------------------------------------------------------
// uer_cfg_if
// Register write channel: register index and write data.
// ----------------------------------------------------------------------------
interface uer_cfg_if;
	import uer_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [15:0]          data;

	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface

FILE: hdl/uer_ctrl.sv
// ----------------------------------------------------------------------------
// uer_ctrl
// Measurement phase machine and conversion sequencer. Decodes each tick into
// datapath commands and steps the two divisions that end a measurement.
// ----------------------------------------------------------------------------
module uer_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  uer_pkg::uer_stat_t st,
	output uer_pkg::uer_cmd_t  cmd
);
	import uer_pkg::*;

	phase_t phase_q, phase_d;
	seq_t   seq_q, seq_d;
	logic   take;

	assign in_ready = (seq_q == SQ_READY) && !st.out_full;
	assign take     = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			seq_q   <= SQ_READY;
		end else begin
			phase_q <= phase_d;
			seq_q   <= seq_d;
		end
	end

	always_comb begin
		phase_d = phase_q;
		seq_d   = seq_q;
		case (seq_q)
			SQ_READY: begin
				if (take) begin
					case (phase_q)
						PH_IDLE: begin
							if (st.start_req) phase_d = PH_TRIG;
						end
						PH_TRIG: begin
							if (st.trig_done) phase_d = PH_WAIT;
						end
						PH_WAIT: begin
							if (st.rise) phase_d = PH_MEAS;
							else if (st.wrapped) phase_d = PH_IDLE;
						end
						PH_MEAS: begin
							if (st.fall) begin
								phase_d = PH_IDLE;
								seq_d   = SQ_DIV1;
							end else if (st.wrapped) begin
								phase_d = PH_IDLE;
							end
						end
						default: phase_d = PH_IDLE;
					endcase
				end
			end
			SQ_DIV1: begin
				if (!st.div_busy) seq_d = SQ_MUL2;
			end
			SQ_MUL2: seq_d = SQ_DIV2;
			SQ_DIV2: begin
				if (!st.div_busy) seq_d = SQ_READY;
			end
			default: seq_d = SQ_READY;
		endcase
	end

	always_comb begin
		cmd = '0;
		case (seq_q)
			SQ_READY: begin
				if (take) begin
					cmd.tick = 1'b1;
					cmd.push = 1'b1;
					case (phase_q)
						PH_IDLE: begin
							if (st.start_req) begin
								cmd.latch   = 1'b1;
								cmd.trig_on = 1'b1;
								cmd.busy    = 1'b1;
							end
						end
						PH_TRIG: begin
							cmd.busy = 1'b1;
							if (!st.trig_done) begin
								cmd.pulse_inc = 1'b1;
								cmd.trig_on   = 1'b1;
							end
						end
						PH_WAIT: begin
							if (st.rise) begin
								cmd.cnt_clear = 1'b1;
								cmd.busy      = 1'b1;
							end else if (st.wrapped) begin
								cmd.done   = 1'b1;
								cmd.noecho = 1'b1;
							end else begin
								cmd.busy = 1'b1;
							end
						end
						PH_MEAS: begin
							if (st.fall) begin
								// The result is pushed once both divisions finish.
								cmd.mul1 = 1'b1;
								cmd.push = 1'b0;
							end else if (st.wrapped) begin
								cmd.done   = 1'b1;
								cmd.noecho = 1'b1;
							end else begin
								cmd.busy = 1'b1;
							end
						end
						default: cmd.push = 1'b1;
					endcase
				end
			end
			SQ_DIV1: begin
				cmd.div_step = st.div_busy;
			end
			SQ_MUL2: begin
				cmd.mul2 = 1'b1;
			end
			SQ_DIV2: begin
				if (st.div_busy) begin
					cmd.div_step = 1'b1;
				end else begin
					cmd.push     = 1'b1;
					cmd.from_div = 1'b1;
				end
			end
			default: cmd = '0;
		endcase
	end

endmodule

FILE: hdl/uer_dp.sv
// ----------------------------------------------------------------------------
// uer_dp
// Ranging datapath: configuration registers, tick and pulse counters, edge
// detection, speed of sound, a shared restoring divider and a two-entry
// result queue.
// ----------------------------------------------------------------------------
module uer_dp #(
	parameter int COUNTER_WIDTH = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  uer_pkg::tick_item_t           in_data,
	input  logic                          cfg_we,
	input  logic [uer_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]                   cfg_data,
	input  uer_pkg::uer_cmd_t             cmd,
	output uer_pkg::uer_stat_t            st,
	output logic                          out_valid,
	input  logic                          out_ready,
	output uer_pkg::result_item_t         out_data
);
	import uer_pkg::*;

	// Dividend width covers both count * 1000 and microseconds * 100.
	localparam int DW  = (COUNTER_WIDTH + 10 > 23) ? COUNTER_WIDTH + 10 : 23;
	localparam int DCW = $clog2(DW + 1);

	logic [15:0]              tpm_q;
	logic [15:0]              trig_ticks_q;
	logic [COUNTER_WIDTH-1:0] cnt_q;
	logic [15:0]              pulse_q;
	logic                     prev_q;
	logic [2:0]               sensor_q;
	logic [AIR_W-1:0]         a_q;
	logic [6:0]               hund_q;
	logic [AIR_W-1:0]         air_q;

	logic [DW-1:0]  dvd_q;
	logic [15:0]    rem_q;
	logic [15:0]    dvs_q;
	logic [DCW-1:0] dcnt_q;
	logic [15:0]    us_q;

	logic [15:0]       trig_len;
	logic [16:0]       rem_sh;
	logic [16:0]       rem_sub;
	logic              q_bit;
	logic [2:0]        sensor_sel;
	logic [7:0]        trig_bits;
	logic [2*AIR_W-1:0] recip_prod;
	result_item_t      push_data;

	result_item_t slot_q [2];
	logic [1:0]   fill_q;
	logic [1:0]   fill_after;
	logic         pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tpm_q        <= TICKS_PER_MS_RST;
			trig_ticks_q <= TRIGGER_TICKS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TICKS_PER_MS:  tpm_q        <= cfg_data;
				REG_TRIGGER_TICKS: trig_ticks_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign trig_len = (trig_ticks_q == 16'd0) ? 16'd1 : trig_ticks_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			prev_q   <= 1'b0;
			pulse_q  <= '0;
			sensor_q <= '0;
		end else begin
			if (cmd.tick) begin
				prev_q <= in_data.echo_level;
				cnt_q  <= cmd.cnt_clear ? '0 : cnt_q + 1'b1;
			end
			if (cmd.latch) begin
				sensor_q <= in_data.sensor_index;
				pulse_q  <= 16'd1;
			end else if (cmd.pulse_inc) begin
				pulse_q <= pulse_q + 16'd1;
			end
		end
	end

	// Speed of sound passes through a_q, hund_q and air_q after the start tick
	// and settles long before the first division can finish.
	assign recip_prod = (2*AIR_W)'(a_q) * (2*AIR_W)'(RECIP_100);

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			a_q <= AIR_BASE + AIR_W'(in_data.temperature_c) * AIR_SLOPE;
		end
		hund_q <= recip_prod[RECIP_SHIFT +: 7];
		air_q  <= a_q - (AIR_W'(hund_q) << 4) + AIR_W'(hund_q);
	end

	assign rem_sh  = {rem_q, dvd_q[DW-1]};
	assign rem_sub = rem_sh - {1'b0, dvs_q};
	assign q_bit   = (rem_sh >= {1'b0, dvs_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dcnt_q <= '0;
		end else if (cmd.mul1 || cmd.mul2) begin
			dcnt_q <= DCW'(DW);
		end else if (cmd.div_step) begin
			dcnt_q <= dcnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mul1) begin
			dvd_q <= DW'(cnt_q) * DW'(US_PER_MS);
			rem_q <= '0;
			dvs_q <= (tpm_q == 16'd0) ? 16'd1 : tpm_q;
		end else if (cmd.mul2) begin
			us_q  <= dvd_q[15:0];
			dvd_q <= DW'(dvd_q[15:0]) * DW'(CM_SCALE);
			rem_q <= '0;
			dvs_q <= 16'(air_q);
		end else if (cmd.div_step) begin
			rem_q <= q_bit ? rem_sub[15:0] : rem_sh[15:0];
			dvd_q <= {dvd_q[DW-2:0], q_bit};
		end
	end

	assign sensor_sel = cmd.latch ? in_data.sensor_index : sensor_q;
	assign trig_bits  = (cmd.trig_on && (int'(sensor_sel) < SENSOR_COUNT))
		? (8'd1 << sensor_sel) : 8'd0;

	always_comb begin
		push_data = '0;
		if (cmd.from_div) begin
			push_data.done_res     = 1'b1;
			push_data.microseconds = us_q;
			push_data.centimeters  = dvd_q[11:1];
		end else begin
			push_data.trigger_lines = trig_bits;
			push_data.busy_res      = cmd.busy;
			push_data.done_res      = cmd.done;
			push_data.no_echo       = cmd.noecho;
		end
	end

	assign pop        = (fill_q != 2'd0) && out_ready;
	assign fill_after = fill_q - {1'b0, pop};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else begin
			fill_q <= fill_after + {1'b0, cmd.push};
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			slot_q[0] <= slot_q[1];
		end
		if (cmd.push) begin
			slot_q[fill_after[0]] <= push_data;
		end
	end

	assign out_valid = (fill_q != 2'd0);
	assign out_data  = slot_q[0];

	assign st.start_req = in_data.cmd;
	assign st.rise      = !prev_q && in_data.echo_level;
	assign st.fall      = prev_q && !in_data.echo_level;
	assign st.wrapped   = &cnt_q;
	assign st.trig_done = (pulse_q >= trig_len);
	assign st.div_busy  = (dcnt_q != '0);
	assign st.out_full  = (fill_q == 2'd2);

endmodule

FILE: hdl/ultrasonic_echo_ranging_unit.sv
// ----------------------------------------------------------------------------
// ultrasonic_echo_ranging_unit
// Ultrasonic time-of-flight ranging: trigger pulse, echo timing, and
// conversion of the echo width into microseconds and centimeters.
// ----------------------------------------------------------------------------
//   Channel  Role   Payload                              Transaction
//   tick     sink   cmd, echo_level, sensor, temperature one timer tick
//   result   source trigger, busy, done, no_echo, us, cm one result per tick
//   cfg      sink   index, data                          one register write
//
// The tick that ends a measurement on the echo falling edge starts two
// divisions with a dividend of DW = max(COUNTER_WIDTH+10, 23) bits on the
// shared restoring divider, one quotient bit a cycle; tick waits until both end.
// Reset is asynchronous and active low; no clearing pass follows it.
// Results wait in a two-entry queue; outside a conversion, tick is held off
// only while that queue is full.
// ----------------------------------------------------------------------------
module ultrasonic_echo_ranging_unit #(
	parameter int COUNTER_WIDTH = 16
) (
	input logic        clk,
	input logic        arst_n,
	uer_tick_if.sink   tick,
	uer_result_if.source result,
	uer_cfg_if.sink    cfg
);
	import uer_pkg::*;

	uer_cmd_t  cmd;
	uer_stat_t st;

	assign cfg.ready = 1'b1;

	uer_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (tick.valid),
		.in_ready (tick.ready),
		.st       (st),
		.cmd      (cmd)
	);

	uer_dp #(
		.COUNTER_WIDTH (COUNTER_WIDTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (tick.data),
		.cfg_we    (cfg.valid),
		.cfg_index (cfg.index),
		.cfg_data  (cfg.data),
		.cmd       (cmd),
		.st        (st),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.out_data  (result.data)
	);

endmodule

FILE: hdl/uer_checker.sv
// ----------------------------------------------------------------------------
// uer_checker
// Port-level checks on the ranging unit's result channel.
// ----------------------------------------------------------------------------
module uer_checker (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  out_valid,
	input logic                  out_ready,
	input uer_pkg::result_item_t out_data
);
	import uer_pkg::*;

	// A result that waits must not change under the consumer.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// A finished measurement is never reported as still running.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.done_res |-> !out_data.busy_res
			&& (out_data.trigger_lines == 8'd0))
		else $error("done result shows busy or trigger");

	// No echo ends a measurement and carries zero width and distance.
	a_no_echo: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.no_echo |-> out_data.done_res
			&& (out_data.microseconds == 16'd0) && (out_data.centimeters == 11'd0))
		else $error("no echo result malformed");

	// Only one trigger line is driven, and only while busy.
	a_trig: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> $onehot0(out_data.trigger_lines)
			&& (out_data.busy_res || (out_data.trigger_lines == 8'd0)))
		else $error("bad trigger lines");

endmodule

bind ultrasonic_echo_ranging_unit uer_checker u_uer_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.out_data  (result.data)
);
